FILE: sv/rot_pkg.sv
// Package for the range offset translator.
// Holds item and result types, the table entry width, operation and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none

package rot_pkg;

  localparam int OFFSET_W = 32;
  localparam int ENTRY_W  = 2 * OFFSET_W;   // {start, partner}

  typedef logic [1:0] op_t;
  localparam op_t OP_MAP     = 2'd0;
  localparam op_t OP_F2V     = 2'd1;
  localparam op_t OP_V2F     = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_NO_RANGE   = 2'd1;
  localparam status_t ST_NO_PARTNER = 2'd2;
  localparam status_t ST_FULL       = 2'd3;

  typedef struct packed {
    op_t                 op;
    logic [OFFSET_W-1:0] voff;
    logic [OFFSET_W-1:0] foff;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] offset;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_DST,
    S_WRITE,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: sv/rot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module rot_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/rot_ctrl.sv
// Sequencer and scan datapath for the range offset translator.
// Scans both table RAMs entry by entry, keeps valid bits, writes map items.
// Depends on rot_pkg.
`default_nettype none

module rot_ctrl #(
  parameter int MAX_RANGES = 16,
  localparam int IW        = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire rot_pkg::item_t          in_item,
  output logic [IW-1:0]                raddr,
  input  wire logic [rot_pkg::ENTRY_W-1:0] v_rdata,
  input  wire logic [rot_pkg::ENTRY_W-1:0] f_rdata,
  output logic                         v_we,
  output logic [IW-1:0]                v_waddr,
  output logic [rot_pkg::ENTRY_W-1:0]  v_wdata,
  output logic                         f_we,
  output logic [IW-1:0]                f_waddr,
  output logic [rot_pkg::ENTRY_W-1:0]  f_wdata,
  input  wire logic                    out_busy,
  output logic                         res_push,
  output rot_pkg::result_t             res
);

  import rot_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(MAX_RANGES - 1);

  state_t state, state_next;
  item_t  item;

  logic          [IW-1:0] cnt;
  logic                   iss_done;
  logic                   rd_vld;
  logic          [IW-1:0] rd_idx;
  logic [MAX_RANGES-1:0]  virt_valid;
  logic [MAX_RANGES-1:0]  file_valid;

  logic                   v_hit, f_hit, v_free, f_free;
  logic          [IW-1:0] v_slot, f_slot, v_free_slot, f_free_slot;
  logic                   best_found;
  logic    [OFFSET_W-1:0] best_start, best_part, delta;
  logic                   dst_found;
  result_t                res_q;

  logic                   v_ok, f_ok, src_ok, dst_ok;
  logic    [OFFSET_W-1:0] v_start, v_part, f_start, f_part;
  logic    [OFFSET_W-1:0] src_start, src_part, dst_start, query;
  logic                   is_map, is_f2v, scan_last, best_upd, found_any, dst_hit, full;

  // Decode the entry returned by the RAMs this cycle.
  always_comb begin
    v_ok      = rd_vld && virt_valid[rd_idx];
    f_ok      = rd_vld && file_valid[rd_idx];
    v_start   = v_rdata[ENTRY_W-1:OFFSET_W];
    v_part    = v_rdata[OFFSET_W-1:0];
    f_start   = f_rdata[ENTRY_W-1:OFFSET_W];
    f_part    = f_rdata[OFFSET_W-1:0];
    is_map    = (item.op == OP_MAP);
    is_f2v    = (item.op == OP_F2V);
    query     = is_f2v ? item.foff : item.voff;
    src_ok    = is_f2v ? f_ok : v_ok;
    src_start = is_f2v ? f_start : v_start;
    src_part  = is_f2v ? f_part : v_part;
    dst_ok    = is_f2v ? v_ok : f_ok;
    dst_start = is_f2v ? v_start : f_start;
    scan_last = rd_vld && (rd_idx == LAST);
    best_upd  = src_ok && (src_start <= query) && (!best_found || (src_start > best_start));
    found_any = best_found || best_upd;
    dst_hit   = dst_ok && (dst_start == best_part);
    full      = !(v_hit || v_free) || !(f_hit || f_free);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.op == OP_MAP || in_item.op == OP_F2V || in_item.op == OP_V2F) begin
            state_next = S_SRC;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SRC: begin
        if (scan_last) begin
          priority if (is_map) state_next = S_WRITE;
          else if (found_any) state_next = S_DST;
          else state_next = S_RESP;
        end
      end
      S_DST: begin
        if (scan_last) state_next = S_RESP;
      end
      S_WRITE: state_next = S_RESP;
      S_RESP: begin
        if (!out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = (state == S_IDLE);
    res_push = (state == S_RESP) && !out_busy;
    res      = res_q;
    raddr    = cnt;
    v_we     = (state == S_WRITE) && !full;
    f_we     = (state == S_WRITE) && !full;
    v_waddr  = v_hit ? v_slot : v_free_slot;
    f_waddr  = f_hit ? f_slot : f_free_slot;
    v_wdata  = {item.voff, item.foff};
    f_wdata  = {item.foff, item.voff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      virt_valid <= '0;
      file_valid <= '0;
      rd_vld     <= 1'b0;
      iss_done   <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;

      // Address issue: one entry per cycle, restart on entering a scan.
      if ((state == S_IDLE && in_valid) || (state == S_SRC && scan_last)) begin
        cnt      <= '0;
        iss_done <= 1'b0;
        rd_vld   <= 1'b0;
      end else if ((state == S_SRC || state == S_DST) && !iss_done) begin
        rd_vld   <= 1'b1;
        rd_idx   <= cnt;
        cnt      <= cnt + IW'(1);
        iss_done <= (cnt == LAST);
      end else begin
        rd_vld <= 1'b0;
      end

      if (v_we) virt_valid[v_waddr] <= 1'b1;
      if (f_we) file_valid[f_waddr] <= 1'b1;
    end

    // Scan trackers and result; cleared on accept.
    if (state == S_IDLE && in_valid) begin
      item       <= in_item;
      v_hit      <= 1'b0;
      f_hit      <= 1'b0;
      v_free     <= 1'b0;
      f_free     <= 1'b0;
      best_found <= 1'b0;
      dst_found  <= 1'b0;
      res_q      <= '{status: ST_OK, offset: '0};
    end
    if (state == S_SRC && is_map) begin
      if (!v_hit && v_ok && v_start == item.voff) begin
        v_hit  <= 1'b1;
        v_slot <= rd_idx;
      end
      if (!v_free && rd_vld && !v_ok) begin
        v_free      <= 1'b1;
        v_free_slot <= rd_idx;
      end
      if (!f_hit && f_ok && f_start == item.foff) begin
        f_hit  <= 1'b1;
        f_slot <= rd_idx;
      end
      if (!f_free && rd_vld && !f_ok) begin
        f_free      <= 1'b1;
        f_free_slot <= rd_idx;
      end
    end
    if (state == S_SRC && !is_map) begin
      if (best_upd) begin
        best_found <= 1'b1;
        best_start <= src_start;
        best_part  <= src_part;
      end
      if (scan_last) begin
        delta <= query - (best_upd ? src_start : best_start);
        if (!found_any) res_q.status <= ST_NO_RANGE;
      end
    end
    if (state == S_DST) begin
      if (dst_hit) dst_found <= 1'b1;
      if (scan_last) begin
        if (dst_found || dst_hit) begin
          res_q <= '{status: ST_OK, offset: best_part + delta};
        end else begin
          res_q.status <= ST_NO_PARTNER;
        end
      end
    end
    if (state == S_WRITE && full) begin
      res_q.status <= ST_FULL;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_busy)
    else $error("result pushed over a held result");

  a_pair_write: assert property (@(posedge clk) disable iff (rst)
    v_we || f_we |-> v_we && f_we)
    else $error("only one table of a pair written");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_push && res.status != ST_OK |-> res.offset == '0)
    else $error("error result carries a nonzero offset");

  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == S_SRC || state == S_DST)
    else $error("read data returned outside a scan");

endmodule

`default_nettype wire

FILE: sv/range_offset_translator.sv
// Top level of the range offset translator: two table RAMs, the scan
// sequencer and the result register. Depends on rot_pkg, rot_ram, rot_ctrl.
`default_nettype none

// Translates offsets between a virtual space and a file space through two
// paired tables of MAX_RANGES entries. A map item (operation 0) inserts or
// overwrites a pair {virtual start, file start}; status 3 means a new key
// found no free slot and nothing changed. A translate item (1 file to
// virtual, 2 virtual to file) picks the valid entry with the greatest start
// not above the query, looks up its partner in the other table, and returns
// partner + (query - start) modulo 2^32; status 1 means no entry lies at or
// below the query, status 2 means the partner is not in the other table.
// Operation 3 answers ok with zero. Every item yields exactly one result.
// Starts and partners live in one RAM per table with a registered read;
// valid bits are flip-flops cleared by reset. One item is worked at a
// time, and each scan walks the RAM one entry per cycle. A map item runs
// one scan and then a write state, a translate item two scans (the second
// is skipped when no range is found), and operation 3 goes straight to the
// response state. A stalled receiver holds the sequencer in its response
// state. The next item is accepted while the previous result waits in the
// output register.
module range_offset_translator #(
  parameter int MAX_RANGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] virtual_offset,
  input  wire logic [31:0] file_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      translated_offset
);

  import rot_pkg::*;

  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  item_t             in_item;
  logic [IW-1:0]     raddr;
  logic [ENTRY_W-1:0] v_rdata, f_rdata, v_wdata, f_wdata;
  logic              v_we, f_we;
  logic [IW-1:0]     v_waddr, f_waddr;
  logic              res_push;
  result_t           res;

  assign in_item = '{op: operation, voff: virtual_offset, foff: file_offset};

  // Virtual table: entry is {virtual start, file start}.
  rot_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_virt_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (raddr),
    .rdata (v_rdata)
  );

  // File table: entry is {file start, virtual start}.
  rot_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_file_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (raddr),
    .rdata (f_rdata)
  );

  rot_ctrl #(.MAX_RANGES(MAX_RANGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .raddr    (raddr),
    .v_rdata  (v_rdata),
    .f_rdata  (f_rdata),
    .v_we     (v_we),
    .v_waddr  (v_waddr),
    .v_wdata  (v_wdata),
    .f_we     (f_we),
    .f_waddr  (f_waddr),
    .f_wdata  (f_wdata),
    .out_busy (out_valid && !out_ready),
    .res_push (res_push),
    .res      (res)
  );

  // Output register: load on push, drop once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_push) begin
      status            <= res.status;
      translated_offset <= res.offset;
    end
  end

endmodule

`default_nettype wire

FILE: sim/rot_result_check.sv
// Result checker for the range offset translator testbench: watches both
// channels, mirrors the paired range tables and compares every result.
// Depends on rot_pkg for the operation, status and result types.
module rot_result_check #(
  parameter int MAX_RANGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] virtual_offset,
  input  logic [31:0] file_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [31:0] translated_offset,
  output int          mismatch_count,
  output int          pending_results
);
  import rot_pkg::*;

  // Mirror of the two tables: key start and partner start per slot.
  logic        v_used [MAX_RANGES];
  logic [31:0] v_key  [MAX_RANGES];
  logic [31:0] v_link [MAX_RANGES];
  logic        f_used [MAX_RANGES];
  logic [31:0] f_key  [MAX_RANGES];
  logic [31:0] f_link [MAX_RANGES];

  result_t expected_results[$];
  result_t want;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count = mismatch_count + 1;
  endtask

  function automatic int exact_index(input bit file_side, input logic [31:0] key);
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (file_side ? (f_used[i] && f_key[i] == key) : (v_used[i] && v_key[i] == key))
        return i;
    end
    return -1;
  endfunction

  // Matching slot, else the lowest free one, else -1.
  function automatic int map_slot(input bit file_side, input logic [31:0] key);
    int slot;
    slot = exact_index(file_side, key);
    if (slot >= 0)
      return slot;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (!(file_side ? f_used[i] : v_used[i]))
        return i;
    end
    return -1;
  endfunction

  function automatic int floor_index(input bit file_side, input logic [31:0] query);
    int          best;
    logic        used;
    logic [31:0] start;
    logic [31:0] best_start;
    best = -1;
    best_start = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      used  = file_side ? f_used[i] : v_used[i];
      start = file_side ? f_key[i] : v_key[i];
      if (used && start <= query && (best < 0 || start > best_start)) begin
        best = i;
        best_start = start;
      end
    end
    return best;
  endfunction

  function automatic result_t translate_offset(input bit from_file,
                                               input logic [31:0] query);
    result_t     r;
    int          src;
    int          dst;
    logic [31:0] src_start;
    logic [31:0] link;
    r.status = ST_OK;
    r.offset = '0;
    src = floor_index(from_file, query);
    if (src < 0) begin
      r.status = ST_NO_RANGE;
    end else begin
      src_start = from_file ? f_key[src] : v_key[src];
      link      = from_file ? f_link[src] : v_link[src];
      dst = exact_index(!from_file, link);
      if (dst < 0)
        r.status = ST_NO_PARTNER;
      else
        r.offset = (from_file ? v_key[dst] : f_key[dst]) + (query - src_start);
    end
    return r;
  endfunction

  // Work out the result of one item and update the mirrored tables.
  task automatic predict_result(input op_t op, input logic [31:0] voff,
                                input logic [31:0] foff, output result_t r);
    int vs;
    int fs;
    r.status = ST_OK;
    r.offset = '0;
    case (op)
      OP_MAP: begin
        vs = map_slot(1'b0, voff);
        fs = map_slot(1'b1, foff);
        if (vs < 0 || fs < 0) begin
          r.status = ST_FULL;
        end else begin
          v_used[vs] = 1'b1;
          v_key[vs]  = voff;
          v_link[vs] = foff;
          f_used[fs] = 1'b1;
          f_key[fs]  = foff;
          f_link[fs] = voff;
        end
      end
      OP_F2V: r = translate_offset(1'b1, foff);
      OP_V2F: r = translate_offset(1'b0, voff);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_RANGES; i++) begin
        v_used[i] = 1'b0;
        f_used[i] = 1'b0;
      end
      expected_results.delete();
      pending_results <= 0;
    end else begin
      // Check the outgoing result first: it always belongs to an older item.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d offset %h",
                                    status, translated_offset));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (translated_offset !== want.offset)
            report_mismatch($sformatf("offset %h, expected %h",
                                      translated_offset, want.offset));
        end
      end
      if (in_valid && in_ready) begin
        predict_result(operation, virtual_offset, file_offset, want);
        expected_results.push_back(want);
      end
      pending_results <= expected_results.size();
    end
  end

endmodule

FILE: sim/range_offset_translator_tb.sv
// Testbench top for the range offset translator: clock, reset, stimulus
// and verdict. Depends on rot_pkg, rot_result_check and the block itself.
module range_offset_translator_tb;
  import rot_pkg::*;

  localparam int MAX_RANGES   = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Drain margin: covers the longest translate, with slack to spare.
  localparam int DRAIN_CYCLES = 2 * MAX_RANGES + 10;

  // Operation code 3 has no name in the package; the block answers ok, zero.
  localparam op_t OP_UNUSED = 2'd3;

  // Receiver behavior, switched now and then at random.
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_LIGHT,     // ready at random, with probability 3/4
    RX_HEAVY,     // ready one cycle in four, at random
    RX_CADENCE    // fixed cadence: ready three fifths of the time
  } rx_mode_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic [1:0]  operation      = OP_MAP;
  logic [31:0] virtual_offset = '0;
  logic [31:0] file_offset    = '0;
  logic        out_ready      = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [1:0]  status;
  wire  [31:0] translated_offset;

  int       mismatch_count;
  int       pending_results;
  logic     in_taken    = 1'b0;
  int       cycle_count = 0;
  int       burst_left  = 0;
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_left     = 0;

  // Keys handed to the block so far, used to aim queries near real ranges.
  logic [31:0] virt_keys[$];
  logic [31:0] file_keys[$];

  range_offset_translator #(
    .MAX_RANGES(MAX_RANGES)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .virtual_offset   (virtual_offset),
    .file_offset      (file_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .translated_offset(translated_offset)
  );

  rot_result_check #(
    .MAX_RANGES(MAX_RANGES)
  ) u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .virtual_offset   (virtual_offset),
    .file_offset      (file_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .translated_offset(translated_offset),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results)
  );

  always #2 clk = ~clk;

  // Record each input handshake so the sender can look at it on the next
  // falling edge, well away from the rising edge that moved the item.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("range_offset_translator_tb: done, errors");
      $finish;
    end
  end

  // Receiver: pick a new mode now and then, drive ready on the falling edge.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_LIGHT:   out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:   out_ready <= ($urandom_range(0, 3) == 0);
      RX_CADENCE: out_ready <= ((cycle_count % 5) >= 2);
      default:    out_ready <= 1'b1;
    endcase
  end

  // New key: mostly uniform, sometimes hugging either end of the space or
  // a coarse boundary, so the floor search sees both extremes.
  function automatic logic [31:0] fresh_key();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2:       return {8'($urandom_range(0, 255)), 24'h0};
      default: return $urandom();
    endcase
  endfunction

  // Query aimed at a known key of one table: exact hit, just below, just
  // above, far above, or plain random and extreme values.
  function automatic logic [31:0] near_key(input bit file_side);
    int          n;
    logic [31:0] base;
    n = file_side ? file_keys.size() : virt_keys.size();
    if (n == 0)
      return $urandom();
    base = file_side ? file_keys[$urandom_range(0, n - 1)]
                     : virt_keys[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 11))
      0, 1, 2: return base;
      3, 4:    return base - 1;
      5, 6, 7: return base + $urandom_range(1, 255);
      8:       return base + $urandom();
      9:       return '0;
      10:      return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Send one item. Called on a falling edge; return on the falling edge
  // after the item is accepted. Usually idle between bursts of random length.
  task automatic send_item(input op_t op, input logic [31:0] voff,
                           input logic [31:0] foff);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // Mostly short bursts, now and then a long unbroken stretch.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    if (op == OP_MAP) begin
      virt_keys.push_back(voff);
      file_keys.push_back(foff);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    virtual_offset <= voff;
    file_offset    <= foff;
    // Hold the item until the handshake shows up.
    do @(negedge clk); while (!in_taken);
  endtask

  initial begin
    int          sent;
    int          pick;
    op_t         op;
    logic [31:0] voff;
    logic [31:0] foff;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Empty tables: nothing lies below any query.
    send_item(OP_V2F, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_F2V, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // First pair, then hits, misses below, and a far query at the top of the space.
    send_item(OP_MAP, 32'h0000_1000, 32'h0000_0400);
    send_item(OP_V2F, 32'h0000_1000, 32'h0000_0000);
    send_item(OP_V2F, 32'h0000_0FFF, 32'h0000_0000);
    send_item(OP_V2F, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_F2V, 32'h0000_0000, 32'h0000_0400);
    send_item(OP_F2V, 32'h0000_0000, 32'h0000_03FF);
    // Pair whose partner sits near the top: the virtual to file result wraps past zero.
    send_item(OP_MAP, 32'h0000_0000, 32'hFFFF_FFF0);
    send_item(OP_V2F, 32'h0000_0020, 32'h0000_0000);
    send_item(OP_F2V, 32'h0000_0000, 32'hFFFF_FFFF);
    // Existing virtual key: overwrite its partner, file side gets a new key.
    send_item(OP_MAP, 32'h0000_1000, 32'h0000_0800);
    send_item(OP_V2F, 32'h0000_1010, 32'h0000_0000);
    send_item(OP_F2V, 32'h0000_0000, 32'h0000_0410);
    // Extreme keys on both sides.
    send_item(OP_MAP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_V2F, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_F2V, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
    // Same pair again: both tables overwrite in place.
    send_item(OP_MAP, 32'h0000_1000, 32'h0000_0800);

    // Random part: maps mix fresh keys with known ones, so the tables run full
    // and known keys get remapped; lookups aim near known keys.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op   = OP_UNUSED;
        voff = $urandom();
        foff = $urandom();
      end else if (pick < 33) begin
        op   = OP_MAP;
        voff = ($urandom_range(0, 2) == 0)
               ? virt_keys[$urandom_range(0, virt_keys.size() - 1)] : fresh_key();
        foff = ($urandom_range(0, 2) == 0)
               ? file_keys[$urandom_range(0, file_keys.size() - 1)] : fresh_key();
      end else if (pick < 66) begin
        op   = OP_F2V;
        voff = $urandom();
        foff = near_key(1'b1);
      end else begin
        op   = OP_V2F;
        voff = near_key(1'b0);
        foff = $urandom();
      end
      send_item(op, voff, foff);
      if (op != OP_UNUSED)
        sent = sent + 1;
    end
    in_valid <= 1'b0;

    // Drain: wait for every result, then DRAIN_CYCLES more for strays.
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_results == 0)
      $display("range_offset_translator_tb: done, clean");
    else
      $display("range_offset_translator_tb: done, errors");
    $finish;
  end

endmodule
